// ===== design/damped_allpass_reverb_assert.svh =====
// Assertion shorthands for the reverb section. Both expect clk_i and rst_ni in scope.
`ifndef DAMPED_ALLPASS_REVERB_ASSERT_SVH
`define DAMPED_ALLPASS_REVERB_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define DAR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dar_pkg.sv =====
`default_nettype none

package dar_pkg;

  localparam int unsigned MaxDelayDef = 65536;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CoefW   = 15;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDelay    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAllpass  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDamping  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFeedback = 2'd3;

  // reset values
  localparam int unsigned      DelayRst    = 1024;
  localparam logic [CoefW-1:0] AllpassRst  = 15'd21299;
  localparam logic [CoefW-1:0] DampingRst  = 15'd19661;
  localparam logic [CoefW-1:0] FeedbackRst = 15'd19661;

  typedef struct packed {
    logic [CoefW-1:0] alpha;
    logic [CoefW-1:0] damp;
    logic [CoefW-1:0] fb;
  } coef_t;

  // Q1.15 product back to integer, nearest with halves upward.
  function automatic logic signed [32:0] rnd15(input logic signed [47:0] p);
    logic signed [47:0] s;
    s = p + 48'sd16384;
    return s[47:15];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] x);
    if (x > 28'sd8388607) begin
      return 24'sh7fffff;
    end else if (x < -28'sd8388608) begin
      return 24'sh800000;
    end else begin
      return x[23:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/dar_ram.sv =====
`default_nettype none

module dar_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/dar_dist.sv =====
`default_nettype none

// delay_length modulo the memory depth by reciprocal multiplication, in quotient, remainder and correction steps
module dar_dist #(
  parameter int unsigned MaxDelay = dar_pkg::MaxDelayDef,
  localparam int unsigned AW = $clog2(MaxDelay)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dar_pkg::DelayW-1:0]  delay_i,
  output logic                             busy_o,
  output logic      [AW-1:0]               dist_o
);
  import dar_pkg::*;

  localparam int unsigned MW      = $clog2(MaxDelay + 1);
  localparam int unsigned RW      = MW + DelayW;
  localparam int unsigned DistRst = DelayRst % MaxDelay;
  // floor(2^32 / depth): the quotient estimate comes out exact or one short
  localparam logic [31:0]   Recip = 32'((64'd1 << 32) / 64'(MaxDelay));
  localparam logic [RW-1:0] MaxR  = RW'(MaxDelay);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StQuot = 4'b0010,
    StRem  = 4'b0100,
    StFix  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [DelayW-1:0] dly_q, dly_d, quot_q, quot_d;
  logic [RW-1:0]     rem_q, rem_d, r_q, r_d;
  logic [47:0]       prod;
  logic [RW-1:0]     qm;

  always_comb begin
    prod = 48'(dly_q) * 48'(Recip);
    qm   = RW'(quot_q) * MaxR;
  end

  always_comb begin
    state_d = state_q;
    dly_d   = dly_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    r_d     = r_q;
    if (start_i) begin
      dly_d   = delay_i;
      state_d = StQuot;
    end else begin
      case (state_q)
        StQuot: begin
          quot_d  = prod[47:32];
          state_d = StRem;
        end
        StRem: begin
          rem_d   = RW'(dly_q) - qm;
          state_d = StFix;
        end
        StFix: begin
          if (rem_q >= MaxR) begin
            r_d = rem_q - MaxR;
          end else begin
            r_d = rem_q;
          end
          state_d = StIdle;
        end
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dly_q   <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      r_q     <= RW'(DistRst);
    end else begin
      state_q <= state_d;
      dly_q   <= dly_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      r_q     <= r_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign dist_o = r_q[AW-1:0];

endmodule

`default_nettype wire

// ===== design/dar_core.sv =====
`default_nettype none
`include "damped_allpass_reverb_assert.svh"

module dar_core #(
  parameter int unsigned MaxDelay = dar_pkg::MaxDelayDef,
  localparam int unsigned AW = $clog2(MaxDelay)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [dar_pkg::SampleW-1:0]  in_sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [dar_pkg::SampleW-1:0]  out_sample_o,
  input  wire dar_pkg::coef_t               coef_i,
  input  wire logic [AW-1:0]                dist_i,
  input  wire logic                         hold_i
);
  import dar_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMulD = 6'b000010,
    StMulV = 6'b000100,
    StOut  = 6'b001000,
    StWb   = 6'b010000,
    StDamp = 6'b100000
  } state_e;

  localparam logic [AW:0]   MaxW   = (AW + 1)'(MaxDelay);
  localparam logic [AW-1:0] LastWp = AW'(MaxDelay - 1);

  state_e state_q, state_d;
  logic [AW-1:0] wp_q, wp_d, rp;
  logic [AW:0]   rp_wide;
  logic          wrapped_q, wrapped_d;
  logic signed [23:0] dm_q, dm_d;
  logic          out_valid_q, out_valid_d;
  logic [SampleW-1:0] out_q;
  logic          rvalid_q;
  logic          in_fire, out_free;

  logic signed [23:0] x_q, d_q, d_mux;
  logic [SampleW-1:0] rdata;
  logic signed [39:0] p1_q, p4_q;
  logic signed [41:0] pa_q, pf_q;
  logic signed [42:0] p3_q;

  logic signed [15:0] alpha_s, fb_s, damp_s;
  logic signed [16:0] ff_s;
  logic signed [32:0] r1_full, ra_full, rf_full, r3_full, r4_full;
  logic signed [23:0] r1, r4, y, w;
  logic signed [25:0] v, t;
  logic signed [26:0] ra, r3;
  logic signed [27:0] ysum, wsum;

  assign in_ready_o = (state_q == StIdle) && !hold_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // read position, wrapped below zero
  always_comb begin
    if (wp_q >= dist_i) begin
      rp_wide = {1'b0, wp_q} - {1'b0, dist_i};
    end else begin
      rp_wide = {1'b0, wp_q} + MaxW - {1'b0, dist_i};
    end
    rp = rp_wide[AW-1:0];
  end

  // coefficients as signed operands
  assign alpha_s = signed'({1'b0, coef_i.alpha});
  assign fb_s    = signed'({1'b0, coef_i.fb});
  assign damp_s  = signed'({1'b0, coef_i.damp});
  assign ff_s    = signed'({1'b0, 16'h8000 - {1'b0, coef_i.damp}});

  // never written entries read as zero
  assign d_mux = rvalid_q ? signed'(rdata) : 24'sd0;

  always_comb begin
    r1_full = rnd15(48'(p1_q));
    r1      = r1_full[23:0];
    v       = 26'(x_q) - 26'(r1);
    ra_full = rnd15(48'(pa_q));
    ra      = ra_full[26:0];
    ysum    = 28'(ra) + 28'(d_q);
    y       = sat24(ysum);
    rf_full = rnd15(48'(pf_q));
    t       = rf_full[25:0];
    r3_full = rnd15(48'(p3_q));
    r3      = r3_full[26:0];
    wsum    = 28'(r3) + 28'(dm_q);
    w       = sat24(wsum);
    r4_full = rnd15(48'(p4_q));
    r4      = r4_full[23:0];
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    wrapped_d   = wrapped_q;
    dm_d        = dm_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StMulD;
        end
      end
      StMulD: state_d = StMulV;
      StMulV: state_d = StOut;
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StWb;
        end
      end
      StWb: begin
        if (wp_q == LastWp) begin
          wp_d      = '0;
          wrapped_d = 1'b1;
        end else begin
          wp_d = wp_q + 1'b1;
        end
        state_d = StDamp;
      end
      StDamp: begin
        dm_d    = r4;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      dm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      dm_q        <= dm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q      <= signed'(in_sample_i);
      rvalid_q <= wrapped_q || (rp < wp_q);
    end
    if (state_q == StMulD) begin
      d_q  <= d_mux;
      p1_q <= 40'(d_mux) * 40'(alpha_s);
    end
    if (state_q == StMulV) begin
      pa_q <= 42'(v) * 42'(alpha_s);
      pf_q <= 42'(v) * 42'(fb_s);
    end
    if ((state_q == StOut) && out_free) begin
      out_q <= y;
      p3_q  <= 43'(t) * 43'(ff_s);
    end
    if (state_q == StWb) begin
      p4_q <= 40'(w) * 40'(damp_s);
    end
  end

  dar_ram #(
    .Width (SampleW),
    .Depth (MaxDelay)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == StWb),
    .waddr_i (wp_q),
    .wdata_i (w),
    .re_i    (in_fire),
    .raddr_i (rp),
    .rdata_o (rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  `DAR_ASSERT_NEXT(a_accept_starts, in_fire, state_q == StMulD, "accepted word did not start")
  `DAR_ASSERT_NEXT(a_wp_step, state_q == StWb,
                   wp_q == (($past(wp_q) == LastWp) ? '0 : $past(wp_q) + 1'b1),
                   "write position did not advance by one")
  `DAR_ASSERT_NEXT(a_wp_hold, state_q != StWb, $stable(wp_q), "write position moved outside write-back")
  `DAR_ASSERT_ALWAYS(a_out_source, !$rose(out_valid_q) || $past(state_q == StOut),
                     "result raised outside output step")
  `DAR_ASSERT_NEXT(a_wrap_sticky, wrapped_q, wrapped_q, "wrap flag cleared")

endmodule

`default_nettype wire

// ===== design/damped_allpass_reverb.sv =====
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata[23:0] = sample_in
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata[23:0] = sample_out
// cfg       in   cfg_valid_i/cfg_ready_o         cfg_index_i, cfg_data_i
//
// Each word runs memory read, chained multiply steps and write-back of the loop sample
// and damping state before the next word is accepted.
// The result is registered in the output step; an untaken result stalls the
// next word at its output step only.
// Reset loads default coefficients and clears the state; entries not yet written
// read as zero by tracking the write progress. A delay_length write holds input
// ready low while the modulo reduction runs.
`default_nettype none

module damped_allpass_reverb #(
  parameter int unsigned MAX_DELAY = dar_pkg::MaxDelayDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // slave side
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [dar_pkg::SampleW-1:0]   s_axis_tdata_i,  // [23:0] sample_in
  // master side
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [dar_pkg::SampleW-1:0]   m_axis_tdata_o,  // [23:0] sample_out
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dar_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dar_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dar_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DELAY);

  coef_t          coef_q, coef_d;
  logic           cfg_fire;
  logic           dist_start;
  logic           dist_busy;
  logic [AW-1:0]  rd_dist;

  // writes are always taken; the distance unit restarts on a new delay
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign dist_start  = cfg_fire && (cfg_index_i == RegDelay);

  always_comb begin
    coef_d = coef_q;
    if (cfg_fire) begin
      case (cfg_index_i)
        RegAllpass:  coef_d.alpha = cfg_data_i[CoefW-1:0];
        RegDamping:  coef_d.damp  = cfg_data_i[CoefW-1:0];
        RegFeedback: coef_d.fb    = cfg_data_i[CoefW-1:0];
        default: ;  // delay length goes to the distance unit
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.alpha <= AllpassRst;
      coef_q.damp  <= DampingRst;
      coef_q.fb    <= FeedbackRst;
    end else begin
      coef_q <= coef_d;
    end
  end

  // read distance, reduced modulo the memory depth
  dar_dist #(
    .MaxDelay (MAX_DELAY)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .delay_i (cfg_data_i[DelayW-1:0]),
    .busy_o  (dist_busy),
    .dist_o  (rd_dist)
  );

  // sequencer, arithmetic and delay memory
  dar_core #(
    .MaxDelay (MAX_DELAY)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_sample_i  (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_sample_o (m_axis_tdata_o),
    .coef_i       (coef_q),
    .dist_i       (rd_dist),
    .hold_i       (dist_busy)
  );

endmodule

`default_nettype wire

// ===== tb/sv/damped_allpass_reverb_test.sv =====
`default_nettype none

module damped_allpass_reverb_test;

  import dar_pkg::*;

  // Depth of the echo store, same as the block's default parameter
  localparam int unsigned Depth      = MaxDelayDef;
  // Generous cap, well above the slowest legal run
  localparam int unsigned CycleLimit = 3_000_000;
  localparam logic [SampleW-1:0] PosFull = 24'h7fffff;
  localparam logic [SampleW-1:0] NegFull = 24'h800000;
  localparam logic [CoefW-1:0]   CoefMax = 15'h7fff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [SampleW-1:0]  s_axis_tdata_i  = '0;   // [23:0] sample_in
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [SampleW-1:0]  m_axis_tdata_o;          // [23:0] sample_out
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  damped_allpass_reverb uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------
  // Allpass predictor: own copy of the echo store, write head, damping
  // state and coefficient registers, all starting from reset values.
  // ---------------------------------------------------------------------
  int          echo_mem [Depth];
  int unsigned head     = 0;
  longint      lp_state = 0;

  logic [DelayW-1:0] cfg_delay = DelayW'(DelayRst);
  logic [CoefW-1:0]  cfg_alpha = AllpassRst;
  logic [CoefW-1:0]  cfg_damp  = DampingRst;
  logic [CoefW-1:0]  cfg_fb    = FeedbackRst;

  logic [SampleW-1:0] expected_samples [$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_out      = 0;
  bit          gaps_on        = 1'b1;   // idling on both sides when set
  int unsigned hold_left      = 0;      // remaining receiver stall cycles
  logic [SampleW-1:0] want;

  // Sample times Q1.15 coefficient, nearest with halves upward (floor shift)
  function automatic longint q15_scale(input longint x, input longint c);
    longint p;
    p = x * c + 64'sd16384;
    return p >>> 15;
  endfunction

  function automatic longint clamp24(input longint x);
    if (x > 64'sd8388607) begin
      return 64'sd8388607;
    end else if (x < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return x;
  endfunction

  // One sample through the section; updates the predictor state.
  function automatic logic [SampleW-1:0] allpass_step(input logic [SampleW-1:0] raw);
    longint      x, tap, v, y, w;
    int unsigned rd;
    x   = longint'($signed(raw));
    // zero delay reads the entry about to be overwritten
    rd  = (head + Depth - (cfg_delay % Depth)) % Depth;
    tap = echo_mem[rd];
    v   = x - q15_scale(tap, cfg_alpha);
    y   = clamp24(q15_scale(v, cfg_alpha) + tap);
    w   = clamp24(q15_scale(q15_scale(v, cfg_fb), 32768 - cfg_damp) + lp_state);
    echo_mem[head] = int'(w);
    lp_state = q15_scale(w, cfg_damp);
    head = (head + 1) % Depth;
    return y[SampleW-1:0];
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        return PosFull;
      end
      1: begin
        return NegFull;
      end
      2, 3: begin
        return SampleW'($urandom_range(0, 511)) - SampleW'(256);
      end
      default: begin
        return SampleW'($urandom());
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Drivers. All called at a rising edge; valid is only lowered when a gap
  // follows, so it never drops and rises within one step.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [SampleW-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_samples.push_back(allpass_step(value));
  endtask

  // Only called with the section idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegDelay: begin
        cfg_delay = data;
      end
      RegAllpass: begin
        cfg_alpha = data[CoefW-1:0];
      end
      RegDamping: begin
        cfg_damp = data[CoefW-1:0];
      end
      RegFeedback: begin
        cfg_fb = data[CoefW-1:0];
      end
      default: begin
      end
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, wait for every pending word, then let write-back finish.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset coefficients, delay 1024: reads all zero; full-scale and bit patterns
  task automatic test_defaults();
    gaps_on = 1'b1;
    send_sample('0);
    send_sample(PosFull);
    send_sample(NegFull);
    send_sample(24'hffffff);
    send_sample(24'h000001);
    send_sample(24'h555555);
    send_sample(24'haaaaaa);
    settle();
  endtask

  // Bit 15 set on coefficient writes must be dropped; also coefficient extremes
  task automatic test_register_masking();
    write_reg(RegDelay,    16'd3);
    write_reg(RegAllpass,  16'hffff);  // alpha at maximum
    write_reg(RegDamping,  16'h8000);  // taken as zero, full feedforward
    write_reg(RegFeedback, 16'hffff);
    send_sample(24'h400000);
    send_sample(24'hc00000);
    send_sample(PosFull);
    send_sample(24'h123456);
    send_sample(NegFull);
    send_sample(24'h000100);
    settle();
  endtask

  // Short loop with strong feedback: drives loop sample and output to the rails
  task automatic test_saturation();
    write_reg(RegDelay,    16'd1);
    write_reg(RegAllpass,  16'd16384);
    write_reg(RegDamping,  16'd0);
    write_reg(RegFeedback, 16'(CoefMax));
    repeat (3) begin
      send_sample(PosFull);
      send_sample(PosFull);
      send_sample(NegFull);
      send_sample(NegFull);
    end
    settle();
  endtask

  // Zero delay: every read lands on the entry about to be overwritten, which
  // has not been written yet in this lap. Then the longest delay.
  task automatic test_zero_delay();
    gaps_on = 1'b0;
    write_reg(RegDelay,    16'd0);
    write_reg(RegAllpass,  16'd9830);
    write_reg(RegDamping,  16'd0);
    write_reg(RegFeedback, 16'(CoefMax));
    repeat (64) send_sample(SampleW'($urandom()));
    settle();
    gaps_on = 1'b1;
    write_reg(RegDelay, 16'hffff);
    repeat (8) send_sample(rand_sample());
    settle();
  endtask

  function automatic logic [CfgDataW-1:0] rand_coef(input int unsigned phase);
    logic [CfgDataW-1:0] c;
    if (phase == 0) begin
      c = '0;
    end else if (phase == 1) begin
      c = 16'(CoefMax);
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          c = '0;
        end
        1: begin
          c = 16'(CoefMax);
        end
        default: begin
          c = 16'($urandom_range(0, CoefMax));
        end
      endcase
    end
    c[CfgDataW-1] = 1'($urandom());  // ignored bit, both values
    return c;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_delay(input int unsigned phase);
    if (phase == 0) begin
      return '0;
    end else if (phase == 1) begin
      return 16'hffff;
    end
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return 16'hffff;
      end
      2: begin
        return 16'd1;
      end
      3, 4, 5: begin
        return 16'($urandom_range(2, 16));
      end
      6: begin
        return 16'($urandom());
      end
      default: begin
        return 16'($urandom_range(17, 3000));
      end
    endcase
  endfunction

  // Random settings per phase, first phase all lows, second all highs
  task automatic test_random_phases();
    int unsigned n;
    for (int unsigned ph = 0; ph < 12; ph++) begin
      if (ph < 2 || $urandom_range(0, 9) < 7) write_reg(RegDelay, rand_delay(ph));
      if (ph < 2 || $urandom_range(0, 9) < 7) write_reg(RegAllpass, rand_coef(ph));
      if (ph < 2 || $urandom_range(0, 9) < 7) write_reg(RegDamping, rand_coef(ph));
      if (ph < 2 || $urandom_range(0, 9) < 7) write_reg(RegFeedback, rand_coef(ph));
      gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(120, 195);
      repeat (n) send_sample(rand_sample());
      settle();
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls on tready
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      hold_left <= pick_gap();
    end
  end

  // Output check against the oldest pending word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("word %0d: sample_out %h with nothing pending",
                                  words_out, m_axis_tdata_o));
      end else begin
        want = expected_samples.pop_front();
        if (m_axis_tdata_o !== want) begin
          report_mismatch($sformatf("word %0d: sample_out %h, predicted %h",
                                    words_out, m_axis_tdata_o, want));
        end
      end
      words_out++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_register_masking();
    test_saturation();
    test_zero_delay();
    test_random_phases();
    settle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
